// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/labc_pkg.sv =====
package labc_pkg;

  // Field widths of the stream words.
  localparam int KIND_W      = 3;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;
  localparam int PERIOD_W    = 16;

  // Default number of LEDs.
  localparam int LED_COUNT_DEF = 4;

  // Blink period after reset, in milliseconds.
  localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = 16'd1000;

  // Command kinds carried in tuser.
  localparam logic [KIND_W-1:0] KIND_SET_ALL   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SET_ONE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BLINK_CFG = 3'd2;
  localparam logic [KIND_W-1:0] KIND_GET_STATE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_GET_BLINK = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TICK      = 3'd5;

  // Minimum payload lengths.
  localparam logic [7:0] LEN_SET_ALL   = 8'd1;
  localparam logic [7:0] LEN_SET_ONE   = 8'd2;
  localparam logic [7:0] LEN_BLINK_CFG = 8'd4;

  // Operation broadcast to the cell row.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SET_ALL,
    OP_SET_ONE,
    OP_BLINK,
    OP_TICK,
    OP_SNAP
  } op_e;

  // Kind of response the controller is emitting.
  typedef enum logic [1:0] {
    RSP_PLAIN,
    RSP_STATE,
    RSP_BLINK
  } rsp_e;

  // Command seen by every cell.
  typedef struct packed {
    op_e                 op;
    logic                value_nz;
    logic [PERIOD_W-1:0] period;
  } cmd_t;

  // Blink setting handed along the readout chain.
  typedef struct packed {
    logic                en;
    logic [PERIOD_W-1:0] period;
  } rd_t;

endpackage

// ===== rtl/labc_cell.sv =====
module labc_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  labc_pkg::cmd_t cmd_i,
  input  logic          sel_i,
  input  logic          set_bit_i,
  input  logic          shift_i,
  input  labc_pkg::rd_t rd_i,
  output labc_pkg::rd_t rd_o,
  output logic          mask_o,
  output logic          drive_o
);
  import labc_pkg::*;

  logic                en_q, en_d;
  logic [PERIOD_W-1:0] per_q, per_d;
  logic [PERIOD_W-1:0] elapsed_q, elapsed_d;
  logic                phase_q, phase_d;
  logic                mask_q, mask_d;
  logic                drive_q, drive_d;
  rd_t                 rd_q;
  logic [PERIOD_W-1:0] elapsed_inc;
  logic                toggle;

  // Saturating millisecond count and the half-period compare.
  always_comb begin
    elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 16'd1;
    toggle = en_q && (per_q != '0) && (elapsed_inc >= {1'b0, per_q[PERIOD_W-1:1]});
  end

  // Next state of this LED for the broadcast command.
  always_comb begin
    en_d      = en_q;
    per_d     = per_q;
    elapsed_d = elapsed_q;
    phase_d   = phase_q;
    mask_d    = mask_q;
    drive_d   = drive_q;
    unique case (cmd_i.op)
      OP_SET_ALL: begin
        mask_d  = set_bit_i;
        drive_d = set_bit_i;
      end
      OP_SET_ONE: begin
        if (sel_i) begin
          mask_d  = cmd_i.value_nz;
          drive_d = cmd_i.value_nz;
        end
      end
      OP_BLINK: begin
        if (sel_i) begin
          en_d      = cmd_i.value_nz;
          per_d     = cmd_i.period;
          elapsed_d = '0;
          phase_d   = 1'b0;
        end
      end
      OP_TICK: begin
        if (toggle) begin
          elapsed_d = '0;
          phase_d   = ~phase_q;
          drive_d   = ~phase_q;
        end else begin
          elapsed_d = elapsed_inc;
        end
      end
      OP_NONE, OP_SNAP: begin
      end
      default: begin
      end
    endcase
  end

  // LED state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q      <= 1'b0;
      per_q     <= DEFAULT_PERIOD;
      elapsed_q <= '0;
      phase_q   <= 1'b0;
      mask_q    <= 1'b0;
      drive_q   <= 1'b0;
    end else begin
      en_q      <= en_d;
      per_q     <= per_d;
      elapsed_q <= elapsed_d;
      phase_q   <= phase_d;
      mask_q    <= mask_d;
      drive_q   <= drive_d;
    end
  end

  // Readout stage: take a snapshot, then pass the word of the next cell along.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_SNAP) begin
      rd_q.en     <= en_q;
      rd_q.period <= per_q;
    end else if (shift_i) begin
      rd_q <= rd_i;
    end
  end

  assign rd_o    = rd_q;
  assign mask_o  = mask_q;
  assign drive_o = drive_q;

endmodule

// ===== rtl/led_array_blink_controller_core.sv =====
// Command-driven blink controller for a row of LEDs.
// Input channel (s_axis): one word is one command; tuser carries the kind
// (set_all, set_one, blink_config, get_state, get_blink, tick) and tdata the
// payload length, LED index, value and period. A tick stands for one
// millisecond of blink time.
// Output channel (m_axis): every other command gives one result word, get_blink
// gives LED_COUNT words, one per LED from LED 0 up, with tlast on the final one.
// Each word shows the drive lines after the command has been applied.
// The accepted command moves the block into its emit state, where each result
// word is loaded into the single output register; for get_blink the readout
// chain of the LED cells feeds it one word per cycle while the receiver is
// ready. A new command is taken only after the last word has been loaded.
// s_axis_tready is high only while no result of the previous command is left
// to load. When the receiver stalls, the output word holds and the block
// waits; one further command may be taken while a final word still waits.
// Reset: all LEDs off, blinking disabled, periods of 1000 ms, no word pending.
module led_array_blink_controller_core #(
  parameter int LED_COUNT = labc_pkg::LED_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: payload_length[7:0], led_index[15:8], value[23:16], period[39:24]
  input  logic [labc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: kind[2:0]
  input  logic [labc_pkg::KIND_W-1:0]      s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: led_drive[3:0], read_valid[4], read_value[12:5], read_period[28:13],
  // zero fill[31:29]
  output logic [labc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tlast
);
  import labc_pkg::*;

  localparam int CNT_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic [7:0]          in_len;
  logic [7:0]          in_idx;
  logic [7:0]          in_value;
  logic [PERIOD_W-1:0] in_period;
  logic                accept;
  cmd_t                cmd;
  rsp_e                rsp_d, rsp_q;
  logic                state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                load;
  logic                shift;
  logic                done;
  logic [LED_COUNT-1:0] mask_vec;
  logic [LED_COUNT-1:0] drive_vec;
  logic [7:0]          mask_ext;
  logic [7:0]          drive_ext;
  rd_t                 rd_chain [LED_COUNT+1];

  logic                m_valid_q;
  logic [3:0]          o_drive_q;
  logic                o_rvalid_q;
  logic [7:0]          o_rvalue_q;
  logic [PERIOD_W-1:0] o_rperiod_q;
  logic                o_last_q;

  assign in_len    = s_axis_tdata[7:0];
  assign in_idx    = s_axis_tdata[15:8];
  assign in_value  = s_axis_tdata[23:16];
  assign in_period = s_axis_tdata[39:24];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Decode the accepted word into a broadcast command and a response kind.
  always_comb begin
    cmd.op       = OP_NONE;
    cmd.value_nz = (in_value != 8'd0);
    cmd.period   = in_period;
    rsp_d        = RSP_PLAIN;
    if (accept) begin
      unique case (s_axis_tuser)
        KIND_SET_ALL:   if (in_len >= LEN_SET_ALL) cmd.op = OP_SET_ALL;
        KIND_SET_ONE:   if (in_len >= LEN_SET_ONE) cmd.op = OP_SET_ONE;
        KIND_BLINK_CFG: if (in_len >= LEN_BLINK_CFG) cmd.op = OP_BLINK;
        KIND_GET_STATE: rsp_d = RSP_STATE;
        KIND_GET_BLINK: begin
          cmd.op = OP_SNAP;
          rsp_d  = RSP_BLINK;
        end
        KIND_TICK:      cmd.op = OP_TICK;
        default:        cmd.op = OP_NONE;
      endcase
    end
  end

  // Row of LED cells; the readout chain runs toward cell 0.
  assign rd_chain[LED_COUNT] = '0;

  for (genvar i = 0; i < LED_COUNT; i++) begin : g_cell
    labc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .sel_i     (in_idx == 8'(i)),
      .set_bit_i (in_value[i]),
      .shift_i   (shift),
      .rd_i      (rd_chain[i+1]),
      .rd_o      (rd_chain[i]),
      .mask_o    (mask_vec[i]),
      .drive_o   (drive_vec[i])
    );
  end

  assign mask_ext  = 8'(mask_vec);
  assign drive_ext = 8'(drive_vec);

  // Response sequencing.
  assign load  = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);
  assign shift = load && (rsp_q == RSP_BLINK);
  assign done  = (rsp_q != RSP_BLINK) || (cnt_q == CNT_W'(LED_COUNT - 1));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EMIT;
          cnt_d   = '0;
        end
      end
      ST_EMIT: begin
        if (load) begin
          if (done) state_d = ST_IDLE;
          else cnt_d = cnt_q + CNT_W'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      rsp_q   <= RSP_PLAIN;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (accept) rsp_q <= rsp_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      o_drive_q <= drive_ext[3:0];
      o_last_q  <= done;
      unique case (rsp_q)
        RSP_STATE: begin
          o_rvalid_q  <= 1'b1;
          o_rvalue_q  <= mask_ext;
          o_rperiod_q <= '0;
        end
        RSP_BLINK: begin
          o_rvalid_q  <= 1'b1;
          o_rvalue_q  <= {7'd0, rd_chain[0].en};
          o_rperiod_q <= rd_chain[0].period;
        end
        default: begin
          o_rvalid_q  <= 1'b0;
          o_rvalue_q  <= 8'd0;
          o_rperiod_q <= '0;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'd0, o_rperiod_q, o_rvalue_q, o_rvalid_q, o_drive_q};
  assign m_axis_tlast  = o_last_q;

endmodule

// ===== rtl/labc_checker.sv =====
`include "assert_macros.svh"

module labc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [labc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tlast
);
  import labc_pkg::*;

  // A taken command closes the input in the following cycle.
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // A stalled result word stays offered.
  `ASSERT_NEXT(a_valid_holds, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // Words without read data carry zero read fields.
  `ASSERT_IMPLIES(a_plain_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[4], m_axis_tdata[28:5] == 24'd0)

  // While more words of a command are due, no new command is taken.
  `ASSERT_IMPLIES(a_pending_busy, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

endmodule

bind led_array_blink_controller_core labc_checker u_labc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
